// ----- src/frst_pkg.sv -----
// ---------------------------------------------------------------------------
// frst_pkg: shared types and constants for the Fenwick rank/select unit
// Field widths, microcode word layout, condition flags and the control store.
// ---------------------------------------------------------------------------
package frst_pkg;

   localparam int IDX_W   = 11;   // index, size and position fields
   localparam int POS_W   = 12;   // internal node position, holds up to 2 * 2047
   localparam int DELTA_W = 16;
   localparam int RANK_W  = 32;
   localparam int NODE_W  = 32;

   localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

   typedef enum logic [2:0] {
      PC_CLEAR,
      PC_IDLE,
      PC_ADD_CHK,
      PC_ADD_LOOP,
      PC_SEL_INIT,
      PC_SEL_LOOP,
      PC_DONE
   } pc_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_CLEAR,
      OP_CAPTURE,
      OP_ADD_START,
      OP_ADD_NODE,
      OP_SEL_START,
      OP_SEL_LEVEL,
      OP_RESULT
   } dp_op_type;

   // sequencing: branch = cond ? target : next, loop = cond ? target : stay,
   // dispatch = wait for a word, then select ? target : next
   typedef enum logic [1:0] {
      NX_BRANCH,
      NX_LOOP,
      NX_DISPATCH
   } nx_type;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_CLR_LAST,
      C_ADD_BAD,
      C_ADD_END,
      C_N_ZERO,
      C_STEP_END,
      C_RSP_FREE
   } cond_type;

   typedef struct packed {
      dp_op_type op;
      nx_type    nx;
      cond_type  cond;
      pc_type    target;
   } ctrl_word_type;

   typedef struct packed {
      logic clr_last;
      logic add_bad;
      logic add_end;
      logic n_zero;
      logic step_end;
   } flags_type;

   function automatic ctrl_word_type ucode_rom(input pc_type pc);
      ctrl_word_type w;
      case (pc)
         PC_CLEAR:    w = '{OP_CLEAR,     NX_LOOP,     C_CLR_LAST, PC_IDLE};
         PC_IDLE:     w = '{OP_CAPTURE,   NX_DISPATCH, C_ALWAYS,   PC_SEL_INIT};
         PC_ADD_CHK:  w = '{OP_ADD_START, NX_BRANCH,   C_ADD_BAD,  PC_DONE};
         PC_ADD_LOOP: w = '{OP_ADD_NODE,  NX_LOOP,     C_ADD_END,  PC_DONE};
         PC_SEL_INIT: w = '{OP_SEL_START, NX_BRANCH,   C_N_ZERO,   PC_DONE};
         PC_SEL_LOOP: w = '{OP_SEL_LEVEL, NX_LOOP,     C_STEP_END, PC_DONE};
         PC_DONE:     w = '{OP_RESULT,    NX_LOOP,     C_RSP_FREE, PC_IDLE};
         default:     w = '{OP_NOP,       NX_BRANCH,   C_ALWAYS,   PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ----- src/frst_channels.sv -----
// ---------------------------------------------------------------------------
// frst_channels: valid/ready channels of the Fenwick rank/select unit
// Request channel (action, index, delta, rank) and response channel.
// ---------------------------------------------------------------------------
interface frst_req_if;
   import frst_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      action;
   logic [IDX_W-1:0]          index;
   logic signed [DELTA_W-1:0] delta;
   logic signed [RANK_W-1:0]  rank;

   modport source (output valid, action, index, delta, rank, input ready);
   modport sink   (input valid, action, index, delta, rank, output ready);
endinterface

interface frst_rsp_if;
   import frst_pkg::*;

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] position;
   logic             status;

   modport source (output valid, position, status, input ready);
   modport sink   (input valid, position, status, output ready);
endinterface

// ----- src/frst_useq.sv -----
// ---------------------------------------------------------------------------
// frst_useq: microcode sequencer
// Step counter over the control store, condition select and jump logic.
// ---------------------------------------------------------------------------
module frst_useq (
   input  logic                    clock,
   input  logic                    reset,
   input  frst_pkg::flags_type     flags,
   input  logic                    req_valid,
   input  logic                    req_select,
   input  logic                    rsp_free,
   output frst_pkg::ctrl_word_type ctrl
);
   import frst_pkg::*;

   pc_type upc_ff;
   pc_type upc_in;
   pc_type upc_next;
   logic   cond_true;

   assign ctrl     = ucode_rom(upc_ff);
   assign upc_next = pc_type'(upc_ff + 3'd1);

   always_comb begin
      case (ctrl.cond)
         C_ALWAYS:   cond_true = 1'b1;
         C_CLR_LAST: cond_true = flags.clr_last;
         C_ADD_BAD:  cond_true = flags.add_bad;
         C_ADD_END:  cond_true = flags.add_end;
         C_N_ZERO:   cond_true = flags.n_zero;
         C_STEP_END: cond_true = flags.step_end;
         C_RSP_FREE: cond_true = rsp_free;
         default:    cond_true = 1'b0;
      endcase
   end

   always_comb begin
      upc_in = upc_ff;
      case (ctrl.nx)
         NX_BRANCH: begin
            upc_in = cond_true ? ctrl.target : upc_next;
         end
         NX_LOOP: begin
            if (cond_true) upc_in = ctrl.target;
         end
         NX_DISPATCH: begin
            if (req_valid) upc_in = req_select ? ctrl.target : upc_next;
         end
         default: begin
            upc_in = PC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= PC_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

   a_dispatch_sel: assert property (@(posedge clock) disable iff (reset)
      (ctrl.nx == NX_DISPATCH && req_valid && req_select) |=> upc_ff == PC_SEL_INIT)
      else $error("select word not dispatched to select program");

   a_clear_exit: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == PC_CLEAR) |=> (upc_ff == PC_CLEAR || upc_ff == PC_IDLE))
      else $error("clearing pass left to a step other than idle");

endmodule

// ----- src/frst_dpath.sv -----
// ---------------------------------------------------------------------------
// frst_dpath: node memory and datapath
// Node-sum memory, position/step/rank registers, driven by the control word.
// ---------------------------------------------------------------------------
module frst_dpath #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  frst_pkg::ctrl_word_type               ctrl,
   input  logic [frst_pkg::IDX_W-1:0]            n,
   input  logic                                  req_action,
   input  logic [frst_pkg::IDX_W-1:0]            req_index,
   input  logic signed [frst_pkg::DELTA_W-1:0]   req_delta,
   input  logic signed [frst_pkg::RANK_W-1:0]    req_rank,
   output frst_pkg::flags_type                   flags,
   output logic [frst_pkg::IDX_W-1:0]            rsp_position,
   output logic                                  rsp_status
);
   import frst_pkg::*;

   localparam int AW = $clog2(TABLE_SIZE);

   logic [NODE_W-1:0]         mem [TABLE_SIZE];

   logic                      act_ff;
   logic signed [DELTA_W-1:0] delta_ff;
   logic [POS_W-1:0]          i_ff, i_in;
   logic [POS_W-1:0]          step_ff, step_in;
   logic [NODE_W-1:0]         rem_ff, rem_in;
   logic [NODE_W-1:0]         rd_ff;
   logic                      status_ff, status_in;
   logic [AW-1:0]             clr_ff, clr_in;

   logic [POS_W-1:0]          n_pos;
   logic [POS_W-1:0]          lowbit, inext;
   logic [POS_W-1:0]          sel_next, at_n, step_half, step0, pos_plus;
   logic                      take;
   logic                      mem_we;
   logic [AW-1:0]             wr_addr, rd_addr;
   logic [NODE_W-1:0]         wdata;

   function automatic logic [AW-1:0] to_addr(input logic [POS_W-1:0] p);
      logic [POS_W+AW-1:0] w;
      w = {{AW{1'b0}}, p};
      return w[AW-1:0];
   endfunction

   function automatic logic [POS_W-1:0] top_pow(input logic [IDX_W-1:0] v);
      logic [POS_W-1:0] p;
      p = '0;
      for (int b = 0; b < IDX_W; b++) begin
         if (v[b]) p = POS_W'(1) << b;
      end
      return p;
   endfunction

   assign n_pos     = {1'b0, n};
   assign lowbit    = i_ff & (~i_ff + POS_W'(1));
   assign inext     = i_ff + lowbit;
   assign sel_next  = i_ff + step_ff;
   assign take      = (sel_next <= n_pos) && ($signed(rd_ff) < $signed(rem_ff));
   assign at_n      = take ? sel_next : i_ff;
   assign step_half = step_ff >> 1;
   assign step0     = top_pow(n);
   assign pos_plus  = i_ff + POS_W'(1);

   assign flags.clr_last = (clr_ff == AW'(TABLE_SIZE - 1));
   assign flags.add_bad  = (i_ff == '0) || (i_ff > n_pos);
   assign flags.add_end  = (inext > n_pos);
   assign flags.n_zero   = (n == '0);
   assign flags.step_end = (step_half == '0);

   assign rsp_position = act_ff ? pos_plus[IDX_W-1:0] : '0;
   assign rsp_status   = status_ff;

   always_comb begin
      i_in      = i_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      status_in = status_ff;
      clr_in    = clr_ff;
      mem_we    = 1'b0;
      wr_addr   = to_addr(i_ff - POS_W'(1));
      wdata     = rd_ff + {{(NODE_W-DELTA_W){delta_ff[DELTA_W-1]}}, delta_ff};
      rd_addr   = '0;
      case (ctrl.op)
         OP_CLEAR: begin
            mem_we  = 1'b1;
            wr_addr = clr_ff;
            wdata   = '0;
            clr_in  = clr_ff + AW'(1);
         end
         OP_CAPTURE: begin
            i_in      = {1'b0, req_index};
            rem_in    = req_rank;
            status_in = 1'b0;
         end
         OP_ADD_START: begin
            status_in = flags.add_bad;
            rd_addr   = to_addr(i_ff - POS_W'(1));
         end
         OP_ADD_NODE: begin
            mem_we  = 1'b1;
            i_in    = inext;
            rd_addr = to_addr(inext - POS_W'(1));
         end
         OP_SEL_START: begin
            i_in    = '0;
            step_in = step0;
            rd_addr = to_addr(step0 - POS_W'(1));
         end
         OP_SEL_LEVEL: begin
            i_in    = at_n;
            rem_in  = take ? rem_ff - rd_ff : rem_ff;
            step_in = step_half;
            rd_addr = to_addr(at_n + step_half - POS_W'(1));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == OP_CAPTURE) begin
         act_ff   <= req_action;
         delta_ff <= req_delta;
      end
      i_ff      <= i_in;
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wdata;
      rd_ff <= mem[rd_addr];
   end

   a_step_pow2: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_SEL_LEVEL) |-> $onehot(step_ff))
      else $error("select step is not a power of two");

   a_add_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_ADD_NODE) |-> (i_ff != '0 && i_ff <= n_pos))
      else $error("node update outside the covered positions");

   a_add_climb: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_ADD_NODE) |=> (i_ff > $past(i_ff)))
      else $error("update walk did not move to a higher node");

endmodule

// ----- src/fenwick_rank_select_table_unit.sv -----
// ---------------------------------------------------------------------------
// fenwick_rank_select_table_unit: Fenwick tree add / k-th select
// Binary indexed tree of 32-bit signed counts over positions 1..n, where n is
// the size register capped at TABLE_SIZE. One word is processed at a time by
// a microcoded sequencer over a single node memory, one tree node per cycle.
// An add runs capture, index check, node update loop and result; a flagged add
// skips the loop. A select runs capture, start, level loop (skipped at n = 0)
// and result. The node loop is bounded by the memory's one read and one write
// per cycle. After reset a clearing pass zeroes the memory, during which no
// request is taken; size writes are taken at any time but must only be issued
// while the unit is idle. A finished response waits in an output register
// while the next request is accepted.
// ---------------------------------------------------------------------------
module fenwick_rank_select_table_unit #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   frst_req_if.sink                     req_ch,
   frst_rsp_if.source                   rsp_ch,
   input  logic                         csr_we,
   input  logic [frst_pkg::IDX_W-1:0]   csr_wdata
);
   import frst_pkg::*;

   ctrl_word_type    ctrl;
   flags_type        flags;
   logic [IDX_W-1:0] size_ff, size_in;
   logic [IDX_W-1:0] n;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic             rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0] dp_position;
   logic             dp_status;
   logic             rsp_free;
   logic             rsp_load;

   assign n = (32'(size_ff) > TABLE_SIZE) ? IDX_W'(TABLE_SIZE) : size_ff;

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_load = (ctrl.op == OP_RESULT) && rsp_free;

   assign req_ch.ready    = (ctrl.nx == NX_DISPATCH);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.position = rsp_pos_ff;
   assign rsp_ch.status   = rsp_status_ff;

   frst_useq u_useq (
      .clock      (clock),
      .reset      (reset),
      .flags      (flags),
      .req_valid  (req_ch.valid),
      .req_select (req_ch.action),
      .rsp_free   (rsp_free),
      .ctrl       (ctrl)
   );

   frst_dpath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .n            (n),
      .req_action   (req_ch.action),
      .req_index    (req_ch.index),
      .req_delta    (req_ch.delta),
      .req_rank     (req_ch.rank),
      .flags        (flags),
      .rsp_position (dp_position),
      .rsp_status   (dp_status)
   );

   always_comb begin
      size_in       = csr_we ? csr_wdata : size_ff;
      rsp_valid_in  = rsp_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
      rsp_pos_in    = rsp_load ? dp_position : rsp_pos_ff;
      rsp_status_in = rsp_load ? dp_status : rsp_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pos_ff    <= rsp_pos_in;
      rsp_status_ff <= rsp_status_in;
   end

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.op == OP_RESULT))
      else $error("response raised outside the result step");

endmodule

// ----- bench/frst_tb_pkg.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// frst_tb_pkg: bench-side codes for the Fenwick rank/select unit
// Request actions, response status codes and the built tree depth, shared by
// the stimulus top and the scoreboard.
// ---------------------------------------------------------------------------
package frst_tb_pkg;

   localparam int TREE_DEPTH = 1024;

   typedef enum logic {
      ACT_ADD    = 1'b0,
      ACT_SELECT = 1'b1
   } action_type;

   typedef enum logic {
      ST_DONE      = 1'b0,
      ST_BAD_INDEX = 1'b1
   } status_type;

endpackage

// ----- bench/frst_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// frst_checker: scoreboard for the Fenwick rank/select unit
// Watches the request, response and size-register ports, keeps a shadow
// Fenwick tree, computes the response word for every accepted request and
// compares each accepted response against the oldest pending answer.
// ---------------------------------------------------------------------------
module frst_checker (
   input  logic                       clock,
   input  logic                       reset,
   frst_req_if                        req_ch,
   frst_rsp_if                        rsp_ch,
   input  logic                       csr_we,
   input  logic [frst_pkg::IDX_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         pending
);
   import frst_pkg::*;
   import frst_tb_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] position;
      status_type       status;
   } answer_type;

   logic [NODE_W-1:0] node_sums [1:TREE_DEPTH];
   logic [IDX_W-1:0]  size_reg;
   answer_type        answer_q [$];
   int                mismatches = 0;

   // updates the shadow tree for an add and returns the response word
   function automatic answer_type tree_answer(input action_type act,
                                              input logic [IDX_W-1:0] idx,
                                              input logic signed [DELTA_W-1:0] delta,
                                              input logic signed [RANK_W-1:0] rank);
      answer_type               ans;
      int unsigned              n;
      int unsigned              i;
      int unsigned              at;
      int unsigned              span;
      logic signed [NODE_W-1:0] remaining;
      n = (size_reg > TREE_DEPTH) ? TREE_DEPTH : size_reg;
      ans.position = '0;
      ans.status   = ST_DONE;
      if (act == ACT_ADD) begin
         if (idx == 0 || idx > n) begin
            ans.status = ST_BAD_INDEX;
         end else begin
            i = idx;
            while (i <= n) begin
               node_sums[i] = node_sums[i] + {{(NODE_W-DELTA_W){delta[DELTA_W-1]}}, delta};
               i = i + (i & (~i + 1));
            end
         end
      end else if (n == 0) begin
         ans.position = 1;
      end else begin
         span = 1;
         while (span * 2 <= n)
            span = span * 2;
         at = 0;
         remaining = rank;
         while (span > 0) begin
            if (at + span <= n) begin
               if ($signed(node_sums[at + span]) < remaining) begin
                  at = at + span;
                  remaining = remaining - node_sums[at];
               end
            end
            span = span >> 1;
         end
         ans.position = IDX_W'(at + 1);
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         for (int k = 1; k <= TREE_DEPTH; k++)
            node_sums[k] = '0;
         size_reg = SIZE_RESET;
         answer_q.delete();
         pending <= 0;
         fail_count <= mismatches;
      end else begin
         if (csr_we)
            size_reg = csr_wdata;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (answer_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected response word position %0d status %0d",
                           $realtime, rsp_ch.position, rsp_ch.status);
               mismatches++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_ch.position !== want.position || rsp_ch.status !== want.status) begin
                  if (mismatches < 10)
                     $display("%0t: response mismatch: position exp %0d got %0d, status exp %0d got %0d",
                              $realtime, want.position, rsp_ch.position,
                              want.status, rsp_ch.status);
                  mismatches++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            answer_q = {answer_q, tree_answer(action_type'(req_ch.action), req_ch.index,
                                              req_ch.delta, req_ch.rank)};
         pending <= answer_q.size();
         fail_count <= mismatches;
      end
   end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: regression bench for fenwick_rank_select_table_unit
// Drives directed add/select words at the size extremes, then long random
// phases under varying sender gaps and receiver stalls, including one long
// receiver hold-off. The scoreboard beside the unit checks every response.
// ---------------------------------------------------------------------------
module tb;
   import frst_pkg::*;
   import frst_tb_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [IDX_W-1:0] csr_wdata = '0;
   int               fail_count;
   int               pending;
   int               idle_pct = 0;
   int               stall_pct = 0;
   logic             hold_trigger = 1'b0;
   logic             hold_on = 1'b0;
   logic [IDX_W-1:0] cur_size = SIZE_RESET;
   int               running_total = 0;

   frst_req_if req_ch();
   frst_rsp_if rsp_ch();

   fenwick_rank_select_table_unit #(.TABLE_SIZE(TREE_DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   frst_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= !reset && !hold_on && ($urandom_range(99) >= stall_pct);
   end

   // long receiver hold-off while the sender keeps offering words
   initial begin
      wait (hold_trigger);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (400) @(posedge clock);
      hold_on <= 1'b0;
   end

   initial begin
      #12000000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int unsigned covered_size();
      return (cur_size > TREE_DEPTH) ? TREE_DEPTH : cur_size;
   endfunction

   task automatic offer_word(input action_type act, input logic [IDX_W-1:0] idx,
                             input logic signed [DELTA_W-1:0] delta,
                             input logic signed [RANK_W-1:0] rank);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.index  <= idx;
      req_ch.delta  <= delta;
      req_ch.rank   <= rank;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      if (act == ACT_ADD && idx != 0 && idx <= covered_size())
         running_total += delta;
   endtask

   task automatic write_size(input logic [IDX_W-1:0] value);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we   <= 1'b0;
      cur_size = value;
   endtask

   task automatic random_word();
      int unsigned              n;
      int                       pick;
      int                       span;
      logic [IDX_W-1:0]         idx;
      logic signed [DELTA_W-1:0] delta;
      logic signed [RANK_W-1:0] rank;
      n     = covered_size();
      pick  = $urandom_range(99);
      idx   = IDX_W'($urandom);
      rank  = RANK_W'($urandom);
      span  = $urandom_range(99);
      if (span < 70)
         delta = DELTA_W'($urandom_range(24));
      else if (span < 90)
         delta = -DELTA_W'($urandom_range(12));
      else
         delta = DELTA_W'($urandom);
      if (pick < 45) begin
         idx = (n == 0) ? '0 : IDX_W'($urandom_range(1, n));
         offer_word(ACT_ADD, idx, delta, rank);
      end else if (pick < 52) begin
         idx = ($urandom_range(1) == 0) ? '0 : IDX_W'($urandom_range(n + 1, 2047));
         offer_word(ACT_ADD, idx, DELTA_W'($urandom), rank);
      end else if (pick < 92) begin
         rank = RANK_W'(int'($urandom_range((running_total > 0) ? running_total + 5 : 5)) - 2);
         offer_word(ACT_SELECT, idx, delta, rank);
      end else begin
         offer_word(ACT_SELECT, idx, delta, rank);
      end
   endtask

   initial begin
      int               seg;
      logic [IDX_W-1:0] seg_size;
      req_ch.valid  = 1'b0;
      req_ch.action = ACT_ADD;
      req_ch.index  = '0;
      req_ch.delta  = '0;
      req_ch.rank   = '0;
      rsp_ch.ready  = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty tree at full size, then edge indexes and deltas
      offer_word(ACT_SELECT, 11'd0, 16'sd0, 32'sd1);
      offer_word(ACT_SELECT, 11'd2047, -16'sd1, 32'sd0);
      offer_word(ACT_SELECT, 11'd5, 16'sd0, 32'sh8000_0000);
      offer_word(ACT_SELECT, 11'd5, 16'sd0, 32'sh7FFF_FFFF);
      offer_word(ACT_ADD, 11'd0, 16'sd5, 32'sd0);
      offer_word(ACT_ADD, 11'd1025, 16'sd5, 32'sd0);
      offer_word(ACT_ADD, 11'd2047, -16'sd1, -32'sd1);
      offer_word(ACT_ADD, 11'd1, 16'sh7FFF, 32'sd0);
      offer_word(ACT_ADD, 11'd1024, 16'sh8000, 32'sd0);
      offer_word(ACT_ADD, 11'd512, 16'sd3, 32'sd0);
      offer_word(ACT_ADD, 11'd1023, 16'sd1, 32'sd0);
      offer_word(ACT_SELECT, 11'd0, 16'sd0, 32'sd32767);
      offer_word(ACT_SELECT, 11'd0, 16'sd0, 32'sd32768);
      offer_word(ACT_SELECT, 11'd0, 16'sd0, 32'sh7FFF_FFFF);
      offer_word(ACT_SELECT, 11'd0, 16'sd0, 32'sh8000_0000);

      // zero size: adds flagged, selects answer one
      write_size(11'd0);
      offer_word(ACT_ADD, 11'd1, 16'sd4, 32'sd0);
      offer_word(ACT_SELECT, 11'd0, 16'sd0, 32'sd5);

      write_size(11'd1);
      offer_word(ACT_ADD, 11'd1, 16'sd2, 32'sd0);
      offer_word(ACT_ADD, 11'd2, 16'sd2, 32'sd0);
      offer_word(ACT_SELECT, 11'd0, 16'sd0, 32'sd32770);

      // oversized register saturates at the built depth
      write_size(11'd2047);
      offer_word(ACT_ADD, 11'd1024, 16'sd7, 32'sd0);
      offer_word(ACT_ADD, 11'd1025, 16'sd7, 32'sd0);
      offer_word(ACT_SELECT, 11'd0, 16'sd0, 32'sd0);

      for (seg = 0; seg < 8; seg++) begin
         case (seg)
            0: seg_size = 11'd1024;
            1: seg_size = 11'd1;
            2: seg_size = 11'd2047;
            3: seg_size = 11'd37;
            4: seg_size = 11'd1000;
            5: seg_size = 11'd0;
            6: seg_size = 11'd1024;
            default: seg_size = IDX_W'($urandom_range(2, 1023));
         endcase
         write_size(seg_size);
         case (seg % 4)
            0: begin
               idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct = 56;
               stall_pct <= 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct <= 56;
            end
            default: begin
               idle_pct = 10;
               stall_pct <= 10;
            end
         endcase
         if (seg == 0)
            hold_trigger = 1'b1;
         repeat (205)
            random_word();
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
